// File: rtl/cle_pkg.sv
// Shared types and command codes for the circular list engine.
`default_nettype none

package cle_pkg;

  localparam int COMMAND_W = 2;
  localparam int VALUE_W   = 8;
  localparam int COUNT_W   = 5;
  localparam int WINDOW_W  = 8;

  localparam logic [COMMAND_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [COMMAND_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [COMMAND_W-1:0] CMD_ROTATE = 2'd2;
  localparam logic [COMMAND_W-1:0] CMD_QUERY  = 2'd3;

  typedef struct packed {
    logic [COMMAND_W-1:0] command;
    logic [VALUE_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic                error;
    logic                is_empty;
    logic [COUNT_W-1:0]  item_count;
    logic [WINDOW_W-1:0] window_value;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/cle_store.sv
// Item and link memories: one write port each, shared read address, registered read data.
`default_nettype none

module cle_store
  import cle_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int SW    = 4,
  parameter int IW    = 8
) (
  input  logic          clk,
  input  logic          item_we,
  input  logic [SW-1:0] item_waddr,
  input  logic [IW-1:0] item_wdata,
  input  logic          link_we,
  input  logic [SW-1:0] link_waddr,
  input  logic [SW-1:0] link_wdata,
  input  logic [SW-1:0] rd_addr,
  output logic [IW-1:0] item_rdata,
  output logic [SW-1:0] link_rdata
);

  logic [IW-1:0] item_mem [DEPTH];
  logic [SW-1:0] link_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (item_we) begin
      item_mem[item_waddr] <= item_wdata;
    end
    item_rdata <= item_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/circular_list_engine_unit.sv
// Circular list engine top level: command sequencer, free list and result register.
// From accept to result register: insert may pop the free list, then writes and links
// the item; delete unlinks and frees a slot; rotate reads the new window; errors and
// empty query go straight to the result. Next item is accepted the cycle after the
// result is loaded; a query reads one linked slot per cycle from the shared read port.
// Synchronous active-low reset empties the list at once; memories are not cleared.
`default_nettype none

module circular_list_engine_unit
  import cle_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int ITEM_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_POP = 4'd1;
  localparam logic [3:0] S_INS_W   = 4'd2;
  localparam logic [3:0] S_INS_L   = 4'd3;
  localparam logic [3:0] S_DEL_A   = 4'd4;
  localparam logic [3:0] S_DEL_B   = 4'd5;
  localparam logic [3:0] S_ROT_A   = 4'd6;
  localparam logic [3:0] S_ROT_B   = 4'd7;
  localparam logic [3:0] S_QRY     = 4'd8;
  localparam logic [3:0] S_RESP    = 4'd9;

  logic [3:0]           state_r, state_nxt;
  logic [ITEM_BITS-1:0] val_r, val_nxt;
  logic [ITEM_BITS-1:0] win_r, win_nxt;
  logic [SW-1:0]        slot_r, slot_nxt;
  logic [SW-1:0]        cursor_r, cursor_nxt;
  logic [SW-1:0]        nxt_r, nxt_nxt;
  logic [SW-1:0]        fhead_r, fhead_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        fresh_r, fresh_nxt;
  logic [CW-1:0]        fcnt_r, fcnt_nxt;
  logic [CW-1:0]        left_r, left_nxt;
  logic                 found_r, found_nxt;
  logic                 err_r, err_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 item_we;
  logic                 link_we;
  logic [SW-1:0]        link_waddr;
  logic [SW-1:0]        link_wdata;
  logic [SW-1:0]        rd_addr;
  logic [ITEM_BITS-1:0] item_rdata;
  logic [SW-1:0]        link_rdata;
  logic [ITEM_BITS-1:0] in_val;

  assign in_val    = ITEM_BITS'(in_data.value);
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  cle_store #(
    .DEPTH (CAPACITY),
    .SW    (SW),
    .IW    (ITEM_BITS)
  ) u_store (
    .clk        (clk),
    .item_we    (item_we),
    .item_waddr (slot_r),
    .item_wdata (val_r),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .rd_addr    (rd_addr),
    .item_rdata (item_rdata),
    .link_rdata (link_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    win_nxt       = win_r;
    slot_nxt      = slot_r;
    cursor_nxt    = cursor_r;
    nxt_nxt       = nxt_r;
    fhead_nxt     = fhead_r;
    count_nxt     = count_r;
    fresh_nxt     = fresh_r;
    fcnt_nxt      = fcnt_r;
    left_nxt      = left_r;
    found_nxt     = found_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    item_we       = 1'b0;
    link_we       = 1'b0;
    link_waddr    = cursor_r;
    link_wdata    = fhead_r;
    rd_addr       = cursor_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt   = in_val;
          found_nxt = 1'b0;
          err_nxt   = 1'b0;
          case (in_data.command)
            CMD_INSERT: begin
              if (count_r == CAP_C) begin
                err_nxt   = 1'b1;
                state_nxt = S_RESP;
              end else if (fcnt_r != '0) begin
                rd_addr   = fhead_r;
                state_nxt = S_INS_POP;
              end else begin
                slot_nxt  = fresh_r[SW-1:0];
                fresh_nxt = fresh_r + 1'b1;
                state_nxt = S_INS_W;
              end
            end
            CMD_DELETE: begin
              if (count_r == '0) begin
                err_nxt   = 1'b1;
                state_nxt = S_RESP;
              end else if (count_r == CW'(1)) begin
                link_we    = 1'b1;
                link_waddr = cursor_r;
                link_wdata = fhead_r;
                fhead_nxt  = cursor_r;
                fcnt_nxt   = fcnt_r + 1'b1;
                count_nxt  = '0;
                win_nxt    = '0;
                state_nxt  = S_RESP;
              end else begin
                slot_nxt  = nxt_r;
                rd_addr   = nxt_r;
                state_nxt = S_DEL_A;
              end
            end
            CMD_ROTATE: begin
              if (count_r == '0) begin
                err_nxt   = 1'b1;
                state_nxt = S_RESP;
              end else begin
                cursor_nxt = nxt_r;
                rd_addr    = nxt_r;
                state_nxt  = S_ROT_A;
              end
            end
            default: begin
              if (count_r == '0) begin
                state_nxt = S_RESP;
              end else begin
                rd_addr   = cursor_r;
                left_nxt  = count_r;
                state_nxt = S_QRY;
              end
            end
          endcase
        end
      end
      S_INS_POP: begin
        slot_nxt  = fhead_r;
        fhead_nxt = link_rdata;
        fcnt_nxt  = fcnt_r - 1'b1;
        state_nxt = S_INS_W;
      end
      S_INS_W: begin
        item_we    = 1'b1;
        link_we    = 1'b1;
        link_waddr = slot_r;
        nxt_nxt    = slot_r;
        win_nxt    = val_r;
        count_nxt  = count_r + 1'b1;
        if (count_r == '0) begin
          link_wdata = slot_r;
          cursor_nxt = slot_r;
          state_nxt  = S_RESP;
        end else begin
          link_wdata = nxt_r;
          state_nxt  = S_INS_L;
        end
      end
      S_INS_L: begin
        link_we    = 1'b1;
        link_waddr = cursor_r;
        link_wdata = slot_r;
        state_nxt  = S_RESP;
      end
      S_DEL_A: begin
        link_we    = 1'b1;
        link_waddr = cursor_r;
        link_wdata = link_rdata;
        nxt_nxt    = link_rdata;
        rd_addr    = link_rdata;
        state_nxt  = S_DEL_B;
      end
      S_DEL_B: begin
        win_nxt    = item_rdata;
        link_we    = 1'b1;
        link_waddr = slot_r;
        link_wdata = fhead_r;
        fhead_nxt  = slot_r;
        fcnt_nxt   = fcnt_r + 1'b1;
        count_nxt  = count_r - 1'b1;
        state_nxt  = S_RESP;
      end
      S_ROT_A: begin
        nxt_nxt   = link_rdata;
        rd_addr   = link_rdata;
        state_nxt = S_ROT_B;
      end
      S_ROT_B: begin
        win_nxt   = item_rdata;
        state_nxt = S_RESP;
      end
      S_QRY: begin
        if (item_rdata == val_r) begin
          found_nxt = 1'b1;
          state_nxt = S_RESP;
        end else if (left_r == CW'(1)) begin
          state_nxt = S_RESP;
        end else begin
          left_nxt = left_r - 1'b1;
          rd_addr  = link_rdata;
        end
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.found        = found_r;
          out_data_nxt.error        = err_r;
          out_data_nxt.is_empty     = (count_r == '0);
          out_data_nxt.item_count   = COUNT_W'(count_r);
          out_data_nxt.window_value = (count_r == '0) ? '0 : WINDOW_W'(win_r);
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= '0;
      cursor_r    <= '0;
      nxt_r       <= '0;
      fhead_r     <= '0;
      count_r     <= '0;
      fresh_r     <= '0;
      fcnt_r      <= '0;
      left_r      <= '0;
      found_r     <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      cursor_r    <= cursor_nxt;
      nxt_r       <= nxt_nxt;
      fhead_r     <= fhead_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      fcnt_r      <= fcnt_nxt;
      left_r      <= left_nxt;
      found_r     <= found_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("stored count exceeds capacity");

  a_free_balance: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> (CW+1)'(count_r) + (CW+1)'(fcnt_r) == (CW+1)'(fresh_r))
    else $error("free list and stored count out of balance");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != S_IDLE)
    else $error("accepted item did not start work");

  a_query_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_QRY |-> left_r != '0 && left_r <= count_r)
    else $error("query walk count out of range");
`endif

endmodule

`default_nettype wire

// File: dv/circular_list_checker.sv
// Checker for the circular list engine: predicts each result and compares it.
`timescale 1ns / 1ps

module circular_list_checker
  import cle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending,
  output int        result_count,
  output int        error_flags,
  output int        found_hits,
  output int        full_hits
);

  localparam int SLOTS      = 16;
  localparam int MAX_REPORT = 200;

  logic [VALUE_W-1:0] slot_value [SLOTS];
  logic [3:0]         slot_link  [SLOTS];
  logic [3:0]         free_slots [SLOTS];
  int                 free_depth;
  int                 live_count;
  logic [3:0]         cursor;
  out_item_t          list_results [$];
  out_item_t          want;
  out_item_t          next_want;

  function automatic void release_slot(logic [3:0] slot);
    if (free_depth < SLOTS) begin
      free_slots[free_depth[3:0]] = slot;
      free_depth++;
    end
  endfunction

  function automatic out_item_t apply_command(in_item_t it);
    out_item_t  res;
    logic [3:0] slot;
    logic [3:0] victim;
    int         k;
    res = '0;
    case (it.command)
      CMD_INSERT: begin
        if (live_count >= SLOTS || free_depth == 0) begin
          res.error = 1'b1;
        end else begin
          free_depth--;
          slot = free_slots[free_depth[3:0]];
          slot_value[slot] = it.value;
          if (live_count == 0) begin
            slot_link[slot] = slot;
            cursor = slot;
          end else begin
            slot_link[slot] = slot_link[cursor];
            slot_link[cursor] = slot;
          end
          live_count++;
        end
      end
      CMD_DELETE: begin
        if (live_count == 0) begin
          res.error = 1'b1;
        end else if (live_count == 1) begin
          release_slot(cursor);
          live_count = 0;
        end else begin
          victim = slot_link[cursor];
          slot_link[cursor] = slot_link[victim];
          release_slot(victim);
          live_count--;
        end
      end
      CMD_ROTATE: begin
        if (live_count == 0) begin
          res.error = 1'b1;
        end else begin
          cursor = slot_link[cursor];
        end
      end
      default: begin
        slot = cursor;
        for (k = 0; k < live_count; k++) begin
          if (slot_value[slot] == it.value) begin
            res.found = 1'b1;
            break;
          end
          slot = slot_link[slot];
        end
      end
    endcase
    res.is_empty     = (live_count == 0);
    res.item_count   = live_count[COUNT_W-1:0];
    res.window_value = (live_count == 0) ? '0 : slot_value[slot_link[cursor]];
    return res;
  endfunction

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      fail_count++;
      if (fail_count <= MAX_REPORT) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected,
                 actual);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        free_slots[i[3:0]] = i[3:0];
      end
      free_depth   = SLOTS;
      live_count   = 0;
      cursor       = '0;
      list_results.delete();
      fail_count   = 0;
      result_count = 0;
      error_flags  = 0;
      found_hits   = 0;
      full_hits    = 0;
      pending      = 0;
    end else begin
      if (in_valid && !in_stall) begin
        next_want = apply_command(in_data);
        if (in_data.command == CMD_INSERT && !next_want.error && live_count == SLOTS) begin
          full_hits++;
        end
        list_results.push_back(next_want);
      end
      if (out_valid && !out_stall) begin
        result_count++;
        if (out_data.error) begin
          error_flags++;
        end
        if (out_data.found) begin
          found_hits++;
        end
        if (list_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, actual %p", $time, out_data);
        end else begin
          want = list_results.pop_front();
          check_field("found", want.found, out_data.found);
          check_field("error", want.error, out_data.error);
          check_field("is_empty", want.is_empty, out_data.is_empty);
          check_field("item_count", want.item_count, out_data.item_count);
          check_field("window_value", want.window_value, out_data.window_value);
        end
      end
      pending = list_results.size();
    end
  end

endmodule

// File: dv/circular_list_engine_unit_tb.sv
// Testbench top for the circular list engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module circular_list_engine_unit_tb;
  import cle_pkg::*;

  localparam int RANDOM_ITEMS = 1720;
  localparam int PHASE_LEN    = 48;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 600;
  localparam int TIMEOUT_NS   = 8_000_000;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED  = 2;

  localparam int STALL_NONE   = 0;
  localparam int STALL_LIGHT  = 1;
  localparam int STALL_HEAVY  = 2;
  localparam int STALL_TOGGLE = 3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int fail_count;
  int pending;
  int result_count;
  int error_flags;
  int found_hits;
  int full_hits;

  int   sent_count;
  bit   hold_done;
  logic [VALUE_W-1:0] recent_values [8];
  int   recent_wr;

  circular_list_engine_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  circular_list_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .result_count(result_count),
    .error_flags (error_flags),
    .found_hits  (found_hits),
    .full_hits   (full_hits)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  task automatic offer(input logic [COMMAND_W-1:0] command, input logic [VALUE_W-1:0] value);
    in_item_t it;
    it.command = command;
    it.value   = value;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic offer_random(input int n);
    int                   mode;
    int                   roll;
    logic [COMMAND_W-1:0] command;
    logic [VALUE_W-1:0]   value;
    mode  = (n / PHASE_LEN) % 3;
    roll  = $urandom_range(0, 99);
    value = VALUE_W'($urandom_range(0, 255));
    case (mode)
      MODE_GROW:   command = (roll < 55) ? CMD_INSERT : (roll < 70) ? CMD_DELETE :
                             (roll < 85) ? CMD_ROTATE : CMD_QUERY;
      MODE_SHRINK: command = (roll < 15) ? CMD_INSERT : (roll < 70) ? CMD_DELETE :
                             (roll < 85) ? CMD_ROTATE : CMD_QUERY;
      default:     command = (roll < 30) ? CMD_INSERT : (roll < 50) ? CMD_DELETE :
                             (roll < 70) ? CMD_ROTATE : CMD_QUERY;
    endcase
    if (command == CMD_INSERT) begin
      if ($urandom_range(0, 3) == 0) begin
        value = recent_values[3'($urandom_range(0, 7))];
      end
      recent_values[recent_wr[2:0]] = value;
      recent_wr = (recent_wr + 1) % 8;
    end else if (command == CMD_QUERY && $urandom_range(0, 9) < 6) begin
      value = recent_values[3'($urandom_range(0, 7))];
    end
    offer(command, value);
  endtask

  initial begin
    int span;
    int style;
    bit phase;
    out_stall = 1'b0;
    phase     = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!hold_done && sent_count >= HOLD_AT) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end
      style = $urandom_range(STALL_NONE, STALL_TOGGLE);
      span  = $urandom_range(16, 96);
      repeat (span) begin
        @(negedge clk);
        phase = ~phase;
        case (style)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= phase;
        endcase
      end
    end
  end

  initial begin
    int burst;
    int gap;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    sent_count = 0;
    hold_done  = 1'b0;
    recent_wr  = 0;
    for (int i = 0; i < 8; i++) begin
      recent_values[i[2:0]] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    offer(CMD_QUERY, 8'h00);
    offer(CMD_DELETE, 8'hFF);
    offer(CMD_ROTATE, 8'h00);
    offer(CMD_INSERT, 8'h00);
    offer(CMD_DELETE, 8'h00);
    offer(CMD_INSERT, 8'hFF);
    offer(CMD_INSERT, 8'h00);
    offer(CMD_QUERY, 8'hFF);
    offer(CMD_QUERY, 8'hAA);
    offer(CMD_ROTATE, 8'h55);
    offer(CMD_DELETE, 8'h00);
    for (int k = 1; k <= 15; k++) begin
      offer(CMD_INSERT, 8'(k * 17) ^ 8'hA5);
    end
    offer(CMD_INSERT, 8'h7E);
    offer(CMD_QUERY, 8'(17) ^ 8'hA5);

    burst = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
        burst = $urandom_range(1, 24);
      end
      offer_random(n);
      burst--;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (40) @(posedge clk);
    $display("Sent %0d commands and checked %0d results across grow, shrink and mixed phases.",
             sent_count, result_count);
    $display("Saw %0d error flags, %0d query hits and %0d fills to capacity.",
             error_flags, found_hits, full_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
